### rtl/mshu_pkg.sv
// shared constants and bus types for the move slot availability heap
package mshu_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int CLK_W     = 64;
    localparam int CFG_W     = 5;
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    // wide enough for 2*pos+2 without wrapping
    localparam int CHILD_W   = SLOT_W + 2;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
    localparam logic [CLK_W-1:0] CLK_MAX   = '1;

    // broadcast from the sift controller to every cell
    typedef struct packed {
        logic [SLOT_W-1:0] pos;      // heap position being sifted
        logic [CNT_W-1:0]  cnt;      // slots in use
        logic              wr_en;
        logic [SLOT_W-1:0] wr_idx;
        logic [CLK_W-1:0]  wr_data;
    } t_cell_ctl;

    // what one cell offers back: its value if it is a child of pos
    typedef struct packed {
        logic             a_hit;
        logic             b_hit;
        logic [CLK_W-1:0] a_val;
        logic [CLK_W-1:0] b_val;
    } t_cell_tap;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SIFT = 2'b10
    } t_state;

endpackage

### rtl/move_slot_availability_heap_unit.sv
// Move slot availability heap: min-heap of slot free times held in a row of slot cells.
// Input stream (s_axis): tdata carries free_clock, tuser carries uses_slot.
// Output stream (m_axis): tdata carries earliest_send, the heap root as it stood
// before the command. Every accepted command gives exactly one result.
// Config channel (i_cfg_valid/o_cfg_ready/i_cfg_data): active slot count, written by the
// user only while the block is idle (the block does not enforce it); zero counts as one
// slot, above 16 as 16. The result is valid in the cycle after the input transaction.
// Throughput: a command without a slot leaves the block idle for the next command; a slot
// command then sifts the new free time down one heap level a cycle until it settles,
// during which s_axis_tready is low.
// The next command is taken once the sift ends and the output register is free
// or being drained in that cycle, so a stalled receiver holds one result and
// blocks further input only after that.
// Reset (synchronous, active low) clears all slot times to zero, sets the slot
// count to 16 and drops the output valid; no clearing sweep is needed.
module move_slot_availability_heap_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [mshu_pkg::CLK_W-1:0]  s_axis_tdata,  // [63:0] free_clock
    input  logic                        s_axis_tuser,  // [0] uses_slot
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [mshu_pkg::CLK_W-1:0]  m_axis_tdata,  // [63:0] earliest_send
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mshu_pkg::CFG_W-1:0]  i_cfg_data     // [4:0] active_slots
);
    import mshu_pkg::*;

    t_state             r_state, n_state;
    logic [SLOT_W-1:0]  r_pos, n_pos;
    logic [CLK_W-1:0]   r_val, n_val;
    logic [CFG_W-1:0]   r_slots;
    logic               r_out_valid, n_out_valid;
    logic [CLK_W-1:0]   r_out, n_out;

    logic [CNT_W-1:0]   cnt;
    t_cell_ctl          ctl;
    t_cell_tap          taps [MAX_SLOTS];
    logic [CLK_W-1:0]   cell_q [MAX_SLOTS];
    logic               a_hit, b_hit;
    logic [CLK_W-1:0]   a_or, b_or;
    logic [CLK_W-1:0]   ca, cb;
    logic [CHILD_W-1:0] child_a, child_b;
    logic               in_acc;

    // clamp the programmed count into 1..MAX_SLOTS
    always_comb begin
        if (r_slots == '0) begin
            cnt = CNT_W'(1);
        end else if (32'(r_slots) > 32'(MAX_SLOTS)) begin
            cnt = CNT_W'(MAX_SLOTS);
        end else begin
            cnt = CNT_W'(r_slots);
        end
    end

    assign o_cfg_ready   = i_rst_n;
    assign s_axis_tready = i_rst_n && (r_state == ST_IDLE) &&
                           (!r_out_valid || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    generate
        for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
            mshu_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (SLOT_W'(g)),
                .i_ctl   (ctl),
                .o_tap   (taps[g]),
                .o_q     (cell_q[g])
            );
        end
    endgenerate

    // gather the two children of the sift position off the cell row
    always_comb begin
        a_hit = 1'b0;
        b_hit = 1'b0;
        a_or  = '0;
        b_or  = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            a_hit = a_hit | taps[i].a_hit;
            b_hit = b_hit | taps[i].b_hit;
            a_or  = a_or  | taps[i].a_val;
            b_or  = b_or  | taps[i].b_val;
        end
    end

    assign ca      = a_hit ? a_or : CLK_MAX;
    assign cb      = b_hit ? b_or : CLK_MAX;
    assign child_a = CHILD_W'({r_pos, 1'b1});
    assign child_b = CHILD_W'({r_pos, 1'b0}) + CHILD_W'(2);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_val       = r_val;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        ctl.pos     = r_pos;
        ctl.cnt     = cnt;
        ctl.wr_en   = 1'b0;
        ctl.wr_idx  = r_pos;
        ctl.wr_data = r_val;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_out_valid = 1'b1;
                    n_out       = cell_q[0];
                    if (s_axis_tuser) begin
                        n_state = ST_SIFT;
                        n_pos   = '0;
                        n_val   = s_axis_tdata;
                    end
                end
            end
            ST_SIFT: begin
                ctl.wr_en = 1'b1;
                if ((r_val <= ca) && (r_val <= cb)) begin
                    n_state = ST_IDLE;
                end else if (ca < cb) begin
                    // smaller child moves up; it is in the heap so its index fits
                    ctl.wr_data = ca;
                    n_pos       = child_a[SLOT_W-1:0];
                end else begin
                    // ties take the right child
                    ctl.wr_data = cb;
                    n_pos       = child_b[SLOT_W-1:0];
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_slots     <= CFG_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_slots <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_val <= n_val;
        r_out <= n_out;
    end

endmodule

### rtl/mshu_cell.sv
// one heap slot: holds a free time and answers as left or right child of the sift position
module mshu_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mshu_pkg::SLOT_W-1:0] i_idx,
    input  mshu_pkg::t_cell_ctl       i_ctl,
    output mshu_pkg::t_cell_tap       o_tap,
    output logic [mshu_pkg::CLK_W-1:0] o_q
);
    import mshu_pkg::*;

    logic [CLK_W-1:0]   r_q;
    logic [CLK_W-1:0]   n_q;
    logic [CHILD_W-1:0] idx_w;
    logic [CHILD_W-1:0] child_a;
    logic [CHILD_W-1:0] child_b;
    logic               in_heap;
    logic               is_a;
    logic               is_b;

    assign idx_w   = CHILD_W'(i_idx);
    assign child_a = CHILD_W'({i_ctl.pos, 1'b1});
    assign child_b = CHILD_W'({i_ctl.pos, 1'b0}) + CHILD_W'(2);
    // slots past the active count read as missing
    assign in_heap = (CNT_W + 1)'(i_idx) < (CNT_W + 1)'(i_ctl.cnt);
    assign is_a    = in_heap && (idx_w == child_a);
    assign is_b    = in_heap && (idx_w == child_b);

    assign o_tap.a_hit = is_a;
    assign o_tap.b_hit = is_b;
    assign o_tap.a_val = is_a ? r_q : '0;
    assign o_tap.b_val = is_b ? r_q : '0;
    assign o_q         = r_q;

    always_comb begin
        n_q = r_q;
        if (i_ctl.wr_en && (i_ctl.wr_idx == i_idx)) begin
            n_q = i_ctl.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

endmodule

### rtl/mshu_checker.sv
// port-level checks for the move slot availability heap, bound to the top level
module mshu_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        s_axis_tuser,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [mshu_pkg::CLK_W-1:0]  m_axis_tdata
);
    import mshu_pkg::*;

    // reset drops any pending result
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a held result keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // every command transaction yields a result in the next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("command without result");

    // a slot command starts a sift, so no command is taken right after it
    a_sift_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("command taken during sift");

endmodule

bind move_slot_availability_heap_unit mshu_checker u_mshu_checker (.*);

### bench/tb_move_slot_availability_heap_unit.sv
// testbench for the move slot availability heap: random command streams checked against a heap predictor
module tb_move_slot_availability_heap_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mshu_pkg::*;

    localparam int STALL_LIMIT = 4000;

    class slot_heap_scoreboard;
        logic [CLK_W-1:0] free_times [MAX_SLOTS];
        int unsigned      slot_cnt;
        logic [CLK_W-1:0] expected_send [$];
        int               errors;

        function new();
            foreach (free_times[i]) free_times[i] = '0;
            set_slot_count(CFG_RESET);
            errors = 0;
        endfunction

        // zero counts as one slot, anything above the heap size as the full heap
        function void set_slot_count(logic [CFG_W-1:0] val);
            if (val == 0)
                slot_cnt = 1;
            else if (val > MAX_SLOTS)
                slot_cnt = MAX_SLOTS;
            else
                slot_cnt = val;
        endfunction

        function void replace_root(logic [CLK_W-1:0] val);
            int unsigned      pos;
            int unsigned      a_pos;
            int unsigned      b_pos;
            logic [CLK_W-1:0] a_val;
            logic [CLK_W-1:0] b_val;
            pos = 0;
            for (int lvl = 0; lvl <= MAX_SLOTS; lvl++) begin
                a_pos = 2 * pos + 1;
                b_pos = 2 * pos + 2;
                a_val = (a_pos < slot_cnt) ? free_times[a_pos] : CLK_MAX;
                b_val = (b_pos < slot_cnt) ? free_times[b_pos] : CLK_MAX;
                if (val <= a_val && val <= b_val)
                    break;
                // on a tie the second child moves up
                if (a_val < b_val) begin
                    free_times[pos] = a_val;
                    pos = a_pos;
                end else begin
                    free_times[pos] = b_val;
                    pos = b_pos;
                end
                if (pos >= slot_cnt)
                    return;
            end
            free_times[pos] = val;
        endfunction

        function void note_command(bit uses_slot, logic [CLK_W-1:0] free_clock);
            expected_send.push_back(free_times[0]);
            if (uses_slot)
                replace_root(free_clock);
        endfunction

        task report_mismatch(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(logic [CLK_W-1:0] earliest_send);
            logic [CLK_W-1:0] want;
            if (expected_send.size() == 0) begin
                report_mismatch($sformatf("unexpected result earliest_send=%h", earliest_send));
            end else begin
                want = expected_send.pop_front();
                if (earliest_send !== want)
                    report_mismatch($sformatf("earliest_send got %h want %h",
                                              earliest_send, want));
            end
        endtask

        function int pending();
            return expected_send.size();
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [CLK_W-1:0] s_axis_tdata = '0;
    logic             s_axis_tuser = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [CLK_W-1:0] m_axis_tdata;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;

    slot_heap_scoreboard sb = new();

    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    bit               hold_rx = 1'b0;
    logic [CLK_W-1:0] run_clock = '0;
    int               quiet_cycles = 0;

    move_slot_availability_heap_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // receiver: random back-pressure, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_rx)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task send_command(input bit uses_slot, input logic [CLK_W-1:0] free_clock);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= free_clock;
        s_axis_tuser  <= uses_slot;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_command(uses_slot, free_clock);
    endtask

    task wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0)
            @(posedge i_clk);
    endtask

    task write_slot_count(input logic [CFG_W-1:0] val);
        wait_drained();
        // let the sift of the last slot command finish
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_slot_count(val);
    endtask

    // mostly rising clocks a little ahead of the running time, with noise and ties
    task send_random_commands(input int count, input bit with_hold, input bit with_pause);
        logic [CLK_W-1:0] fc;
        int               pick;
        for (int k = 0; k < count; k++) begin
            if (with_hold && k == 40) begin
                fork
                    begin
                        hold_rx <= 1'b1;
                        repeat (300) @(posedge i_clk);
                        hold_rx <= 1'b0;
                    end
                join_none
            end
            if (with_pause && k == 60)
                wait_drained();
            pick = $urandom_range(99);
            run_clock = run_clock + $urandom_range(200);
            if (pick < 70)
                fc = run_clock + $urandom_range(1000);
            else if (pick < 80)
                fc = sb.free_times[$urandom_range(MAX_SLOTS - 1)];
            else if (pick < 92)
                fc = {$urandom, $urandom};
            else if (pick < 96)
                fc = '0;
            else
                fc = CLK_MAX;
            send_command($urandom_range(99) < 75, fc);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] slot_plan [8] = '{5'd16, 5'd2, 5'd5, 5'd9, 5'd16, 5'd3, 5'd13, 5'd31};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ignored clock, zero and max replacement, ties, odd slot counts
        send_command(1'b0, CLK_MAX);
        send_command(1'b1, '0);
        send_command(1'b1, CLK_MAX);
        send_command(1'b1, 64'd100);
        send_command(1'b1, 64'd100);
        send_command(1'b1, 64'd50);
        send_command(1'b0, 64'h5555_5555_5555_5555);
        send_command(1'b1, 64'haaaa_aaaa_aaaa_aaaa);
        write_slot_count(5'd1);
        send_command(1'b1, 64'd7);
        send_command(1'b0, 64'd3);
        send_command(1'b1, CLK_MAX);
        send_command(1'b1, 64'd5);
        write_slot_count(5'd0);
        send_command(1'b1, 64'd9);
        send_command(1'b1, 64'd2);
        write_slot_count(5'd31);
        send_command(1'b1, 64'd40);
        send_command(1'b1, 64'd40);
        send_command(1'b1, 64'd41);
        write_slot_count(5'd17);
        send_command(1'b1, 64'd12);
        send_command(1'b0, '0);
        write_slot_count(5'd16);
        send_command(1'b1, 64'd1);

        for (int ph = 0; ph < 8; ph++) begin
            write_slot_count(slot_plan[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            send_random_commands(115, ph == 2, ph == 5);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
